@@ rtl/core/ocl_pkg.sv @@
`default_nettype none

package ocl_pkg;

    // Field widths of the request and response items.
    localparam int OP_W  = 3;
    localparam int VAL_W = 8;
    localparam int ST_W  = 3;
    localparam int CNT_W = 5;

    // Default list depth.
    localparam int CAPACITY_DEF = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_HEAD  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_MATCH = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load_value;  // capture the search key
        logic            idx_clr;     // scan index to zero
        logic            idx_inc;     // scan index up by one
        logic            rd_en;       // read the entry store
        logic            rd_next;     // read at index + 1 instead of index
        logic            wr_en;       // write the entry store
        logic            wr_shift;    // write at index with read data, else append
        logic            len_inc;
        logic            len_dec;
        logic            len_clr;
        logic            set_status;
        logic [ST_W-1:0] status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic match;      // read data equals the search key
        logic scan_end;   // index has reached the length
        logic shift_end;  // index + 1 has reached the length
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/ocl_if.sv @@
`default_nettype none

// Request channel: one list operation per item.
interface ocl_req_if
    import ocl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [VAL_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// Response channel: status and list count.
interface ocl_rsp_if
    import ocl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ordered_char_list_top.sv @@
// Append, clear and the refused cases answer in the cycle after the item is taken.
// Search alternates read and compare states until a hit or the end of the list.
// Removals move each entry above the gap down through a read state and a write state.
// One item at a time: the next item is taken the cycle after the result leaves.
// The scan loop reads one entry per pass through its read and compare states and sets the rate.
// Reset (synchronous, active low) empties the list; no clearing pass is needed.
`default_nettype none

module ordered_char_list_top
    import ocl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ocl_req_if.sink   i_req,
    ocl_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    ocl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_opcode (i_req.opcode),
        .o_req_ready  (i_req.ready),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // Entry store, length, index and result.
    ocl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_req.value),
        .o_stat   (stat),
        .o_status (o_rsp.status),
        .o_count  (o_rsp.count)
    );

endmodule

`default_nettype wire

@@ rtl/core/ocl_datapath.sv @@
`default_nettype none

module ocl_datapath
    import ocl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic [VAL_W-1:0] i_value,
    output t_stat                 o_stat,
    output logic [ST_W-1:0]       o_status,
    output logic [CNT_W-1:0]      o_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rd_data;
    logic [VAL_W-1:0] r_value;
    logic [ST_W-1:0]  r_status;
    logic [LW-1:0]    r_len,  n_len;
    logic [LW-1:0]    r_idx,  n_idx;
    logic [LW:0]      idx_p1;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    // Address and data selection for the entry store.
    always_comb begin
        idx_p1  = {1'b0, r_idx} + (LW+1)'(1);
        rd_addr = i_cmd.rd_next ? idx_p1[IW-1:0] : r_idx[IW-1:0];
        wr_addr = i_cmd.wr_shift ? r_idx[IW-1:0] : r_len[IW-1:0];
        wr_data = i_cmd.wr_shift ? r_rd_data : i_value;
    end

    // Entry store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Next length and scan index.
    always_comb begin
        n_len = r_len;
        if (i_cmd.len_clr) begin
            n_len = '0;
        end else if (i_cmd.len_inc) begin
            n_len = r_len + LW'(1);
        end else if (i_cmd.len_dec) begin
            n_len = r_len - LW'(1);
        end
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_p1[LW-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_idx <= '0;
        end else begin
            r_len <= n_len;
            r_idx <= n_idx;
        end
    end

    // Search key and result status.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_value) begin
            r_value <= i_value;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.empty     = (r_len == '0);
        o_stat.full      = (r_len >= LW'(CAPACITY));
        o_stat.match     = (r_rd_data == r_value);
        o_stat.scan_end  = (r_idx >= r_len);
        o_stat.shift_end = (idx_p1 >= {1'b0, r_len});
    end

    assign o_status = r_status;
    assign o_count  = CNT_W'(r_len);

endmodule

`default_nettype wire

@@ rtl/core/ocl_ctrl.sv @@
`default_nettype none

module ocl_ctrl
    import ocl_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  wire logic [OP_W-1:0] i_req_opcode,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    input  wire t_stat           i_stat,
    output t_cmd                 o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;  // issue read of entry at index
    localparam logic [2:0] S_SCMP = 3'd2;  // compare entry with key
    localparam logic [2:0] S_HRD  = 3'd3;  // read entry above the gap
    localparam logic [2:0] S_HWR  = 3'd4;  // move it down into the gap
    localparam logic [2:0] S_RESP = 3'd5;  // result waits for the sink

    logic [2:0]      r_state, n_state;
    logic [OP_W-1:0] r_op,    n_op;

    // Sequencer: decodes the operation and steps the scan and shift loops.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op             = i_req_opcode;
                    o_cmd.load_value = 1'b1;
                    o_cmd.idx_clr    = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_RESP;
                    case (i_req_opcode)
                        OP_APPEND: begin
                            if (i_stat.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.wr_en   = 1'b1;
                                o_cmd.len_inc = 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            o_cmd.set_status = 1'b0;
                            n_state          = S_SRD;
                        end
                        OP_REM_HEAD: begin
                            if (i_stat.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.set_status = 1'b0;
                                n_state          = S_HRD;
                            end
                        end
                        OP_REM_MATCH: begin
                            if (i_stat.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.set_status = 1'b0;
                                n_state          = S_SRD;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.len_clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (i_stat.scan_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_FOUND;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_stat.match) begin
                    if (r_op == OP_SEARCH) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FOUND;
                        n_state          = S_RESP;
                    end else begin
                        n_state = S_HRD;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_HRD: begin
                if (i_stat.shift_end) begin
                    o_cmd.len_dec    = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_HWR;
                end
            end
            S_HWR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_HRD;
            end
            S_RESP: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_APPEND;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RESP);

endmodule

`default_nettype wire

@@ tb/tb_ordered_char_list_top.sv @@
`timescale 1ns / 1ps

module tb_ordered_char_list_top
    import ocl_pkg::*;
;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RAND_ITEMS   = 815;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int LIMIT_CYCLES = 600000;

    // Opcodes with no operation behind them; the block must leave the list alone.
    localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
    } t_list_rsp;

    // One directed row; reps repeats the operation with the value counting up.
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] val;
        int               reps;
        bit               typed;
        t_list_rsp        rsp;
    } t_dir_row;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    localparam int DIR_ROWS = 22;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{OP_REM_HEAD,  8'h00, 1,  1'b1, '{ST_EMPTY,     5'd0}},
        '{OP_REM_MATCH, 8'hFF, 1,  1'b1, '{ST_EMPTY,     5'd0}},
        '{OP_SEARCH,    8'h00, 1,  1'b1, '{ST_NOT_FOUND, 5'd0}},
        '{OP_APPEND,    8'h00, 1,  1'b1, '{ST_OK,        5'd1}},
        '{OP_APPEND,    8'hFF, 1,  1'b1, '{ST_OK,        5'd2}},
        '{OP_APPEND,    8'h10, 14, 1'b0, '{ST_OK,        5'd0}},
        '{OP_APPEND,    8'hEE, 1,  1'b1, '{ST_FULL,      5'd16}},
        '{OP_SEARCH,    8'hFF, 1,  1'b1, '{ST_FOUND,     5'd16}},
        '{OP_SEARCH,    8'h55, 1,  1'b1, '{ST_NOT_FOUND, 5'd16}},
        '{OP_REM_MATCH, 8'h55, 1,  1'b1, '{ST_NOT_FOUND, 5'd16}},
        '{OP_REM_MATCH, 8'h1D, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_REM_MATCH, 8'h00, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_REM_MATCH, 8'h15, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_APPEND,    8'h12, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_REM_MATCH, 8'h12, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_SEARCH,    8'h12, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_REM_HEAD,  8'h00, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_RSVD_LO,   8'h00, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_RSVD_MID,  8'hFF, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_RSVD_HI,   8'h5A, 1,  1'b0, '{ST_OK,        5'd0}},
        '{OP_CLEAR,     8'hFF, 1,  1'b1, '{ST_OK,        5'd0}},
        '{OP_CLEAR,     8'h00, 1,  1'b1, '{ST_OK,        5'd0}}
    };

    logic i_clk;
    logic i_rst_n;

    ocl_req_if req_if ();
    ocl_rsp_if rsp_if ();

    ordered_char_list_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the list contents.
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_len;

    t_list_rsp list_rsp_q [$];

    int err_cnt;
    int cycle_cnt;
    bit calm;
    bit hold_req;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Drops the entry at pos and moves the later entries down by one.
    function automatic void drop_entry(int pos);
        int i;
        for (i = pos; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i + 1];
        end
        list_len--;
    endfunction

    // Applies one operation to the shadow list and returns its response.
    function automatic t_list_rsp predict_list_op(logic [OP_W-1:0] op, logic [VAL_W-1:0] val);
        t_list_rsp rsp;
        int        pos;
        int        i;
        rsp.status = ST_OK;
        pos = -1;
        for (i = 0; i < list_len; i++) begin
            if (pos < 0 && list_mem[i] == val) begin
                pos = i;
            end
        end
        case (op)
            OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            OP_SEARCH: begin
                rsp.status = (pos >= 0) ? ST_FOUND : ST_NOT_FOUND;
            end
            OP_REM_HEAD: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    drop_entry(0);
                end
            end
            OP_REM_MATCH: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (pos >= 0) begin
                    drop_entry(pos);
                end else begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        rsp.count = CNT_W'(list_len);
        return rsp;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offers one item, waits for it to be taken and records its response.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                             input bit use_typed, input t_list_rsp typed_rsp);
        int        gap;
        t_list_rsp pred;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.value  <= val;
        do @(posedge i_clk); while (!req_if.ready);
        pred = predict_list_op(op, val);
        list_rsp_q.push_back(use_typed ? typed_rsp : pred);
    endtask

    // Response side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        int on_left;
        stall_left = 0;
        on_left = 0;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
                on_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (on_left > 0) begin
                on_left--;
                rsp_if.ready <= 1'b1;
            end else if (calm || $urandom_range(0, 99) < 60) begin
                on_left = $urandom_range(0, 15);
                rsp_if.ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                rsp_if.ready <= 1'b0;
            end
        end
    end

    // Compare each accepted response with the oldest outstanding one.
    always @(posedge i_clk) begin
        t_list_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (list_rsp_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("unexpected response: status=%0d count=%0d",
                             rsp_if.status, rsp_if.count);
                end
            end else begin
                want = list_rsp_q.pop_front();
                if (rsp_if.status !== want.status || rsp_if.count !== want.count) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch: status exp=%0d got=%0d, count exp=%0d got=%0d",
                                 want.status, rsp_if.status, want.count, rsp_if.count);
                    end
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("tb_ordered_char_list_top: errors");
            $finish;
        end
    end

    initial begin
        int               n_counted;
        int               r;
        int               rv;
        int               mix_left;
        int               t_app;
        int               t_srch;
        int               t_rmm;
        int               t_rmh;
        int               t_clr;
        bit               hold_done;
        t_mix             mix;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] val;

        err_cnt = 0;
        cycle_cnt = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        list_len = 0;
        mix = MIX_EVEN;
        mix_left = 0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.opcode = OP_APPEND;
        req_if.value = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows.
        for (int i = 0; i < DIR_ROWS; i++) begin
            for (int k = 0; k < dir_rows[i].reps; k++) begin
                send_item(dir_rows[i].op, VAL_W'(dir_rows[i].val + k),
                          dir_rows[i].typed, dir_rows[i].rsp);
            end
        end

        // Random part in phases that lean toward filling, draining or neither.
        n_counted = 0;
        while (n_counted < RAND_ITEMS) begin
            if (mix_left == 0) begin
                mix = t_mix'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 80);
                calm = ($urandom_range(0, 4) == 0);
            end
            mix_left--;

            // Hold the response side off while items keep coming.
            if (!hold_done && n_counted == 300) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
                calm = 1'b1;
                mix = MIX_FILL;
            end

            case (mix)
                MIX_FILL: begin
                    t_app = 60; t_srch = 73; t_rmm = 84; t_rmh = 93; t_clr = 97;
                end
                MIX_DRAIN: begin
                    t_app = 15; t_srch = 30; t_rmm = 60; t_rmh = 92; t_clr = 97;
                end
                default: begin
                    t_app = 35; t_srch = 55; t_rmm = 75; t_rmh = 92; t_clr = 96;
                end
            endcase

            r = $urandom_range(0, 99);
            if (r < t_app) begin
                op = OP_APPEND;
            end else if (r < t_srch) begin
                op = OP_SEARCH;
            end else if (r < t_rmm) begin
                op = OP_REM_MATCH;
            end else if (r < t_rmh) begin
                op = OP_REM_HEAD;
            end else if (r < t_clr) begin
                op = OP_CLEAR;
            end else begin
                op = OP_W'(OP_RSVD_LO + $urandom_range(0, 2));
            end

            // Values mostly hit the list or a small pool so that matches are common.
            rv = $urandom_range(0, 99);
            if (list_len > 0 && rv < 45) begin
                val = list_mem[$urandom_range(0, list_len - 1)];
            end else if (rv < 70) begin
                val = VAL_W'($urandom_range(0, 7));
            end else begin
                val = VAL_W'($urandom_range(0, 255));
            end

            send_item(op, val, 1'b0, '0);
            n_counted++;
        end

        req_if.valid <= 1'b0;
        calm = 1'b0;

        while (list_rsp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && list_rsp_q.size() == 0) begin
            $display("tb_ordered_char_list_top: clean");
        end else begin
            $display("tb_ordered_char_list_top: errors");
        end
        $finish;
    end

endmodule
